/* sv/pabrf_pkg.sv */
// Shared types and constants for the packet-admitting byte ring FIFO.
package pabrf_pkg;

	localparam int RING_BYTES_DEF = 32768;
	localparam int MAX_PACKET_DEF = 1023;

	localparam int CMD_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 10;
	localparam int AVAIL_W = 16;
	localparam int CNT32_W = 32;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 168;
	localparam int M_TUSER_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic [BYTE_W-1:0] data_byte;
		logic              packet_start;
		logic [LEN_W-1:0]  packet_length;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  read_byte;
		logic               read_valid;
		logic               packet_dropped;
		logic [AVAIL_W-1:0] bytes_available;
		logic [CNT32_W-1:0] total_bytes;
		logic [CNT32_W-1:0] total_wraps;
		logic [CNT32_W-1:0] packet_count;
		logic [LEN_W-1:0]   last_packet_size;
		logic [CNT32_W-1:0] dropped_packets;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} dp_cmd_t;

endpackage

/* sv/packet_admit_byte_ring_fifo_top.sv */
// Top level of the packet-admitting byte ring FIFO.
// Each request is a write byte, a read byte, a clear or a status query, and each
// yields exactly one response with the popped byte, flags and all counters as they
// stand after the request. A packet is admitted only if its declared length is nonzero,
// at most MAX_PACKET and fits the free space of the ring; otherwise all its bytes are
// dropped, and a nonzero-length packet is counted in dropped_packets. A request passes
// through the states IDLE, EXEC and DONE from acceptance to the next acceptance: IDLE
// takes it in, EXEC updates state and accesses the ring memory, and DONE loads the
// response register. A response that is not taken holds off the next request; one
// taken at the same edge lets the next request in. The ring needs no clearing pass after reset.
module packet_admit_byte_ring_fifo_top
	import pabrf_pkg::*;
#(
	parameter int RING_BYTES = RING_BYTES_DEF,
	parameter int MAX_PACKET = MAX_PACKET_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // data_byte[7:0], packet_length[17:8], zero pad
	input  logic [S_TUSER_W-1:0] s_tuser,  // command[1:0], packet_start[2]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // read_byte[7:0], bytes_available[23:8],
	                                       // total_bytes[55:24], total_wraps[87:56],
	                                       // packet_count[119:88],
	                                       // last_packet_size[129:120],
	                                       // dropped_packets[161:130], zero pad
	output logic [M_TUSER_W-1:0] m_tuser   // read_valid[0], packet_dropped[1]
);

	dp_cmd_t dp_cmd;
	item_t   item;
	result_t result;

	assign item.command       = cmd_t'(s_tuser[1:0]);
	assign item.packet_start  = s_tuser[2];
	assign item.data_byte     = s_tdata[7:0];
	assign item.packet_length = s_tdata[17:8];

	assign m_tdata = {6'd0,
	                  result.dropped_packets,
	                  result.last_packet_size,
	                  result.packet_count,
	                  result.total_wraps,
	                  result.total_bytes,
	                  result.bytes_available,
	                  result.read_byte};
	assign m_tuser = {result.packet_dropped, result.read_valid};

	pabrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_cmd   (dp_cmd)
	);

	pabrf_dp #(
		.RING_BYTES (RING_BYTES),
		.MAX_PACKET (MAX_PACKET)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.dp_cmd (dp_cmd),
		.item   (item),
		.result (result)
	);

endmodule

/* sv/pabrf_ctrl.sv */
// Sequencer for the ring FIFO: accept, execute, load result register.
module pabrf_ctrl
	import pabrf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t dp_cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t st_q;
	state_t st_d;
	logic   ov_q;

	assign s_tready       = (st_q == ST_IDLE) && (!ov_q || m_tready);
	assign m_tvalid       = ov_q;
	assign dp_cmd.capture = s_tvalid && s_tready;
	assign dp_cmd.exec    = (st_q == ST_EXEC);
	assign dp_cmd.load    = (st_q == ST_DONE);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (dp_cmd.capture) begin
					st_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				st_d = ST_DONE;
			end
			ST_DONE: begin
				st_d = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (dp_cmd.load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/pabrf_dp.sv */
// Datapath: ring memory, pointers, admission logic, counters and result register.
module pabrf_dp
	import pabrf_pkg::*;
#(
	parameter int RING_BYTES = RING_BYTES_DEF,
	parameter int MAX_PACKET = MAX_PACKET_DEF
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  dp_cmd_t dp_cmd,
	input  item_t   item,
	output result_t result
);

	localparam int AW = $clog2(RING_BYTES);
	localparam int CW = $clog2(RING_BYTES + 1);
	localparam int SW = ((CW > LEN_W) ? CW : LEN_W) + 1;
	localparam int MW = $clog2(MAX_PACKET + 1);
	localparam int XW = (MW > LEN_W) ? MW : LEN_W;

	logic [BYTE_W-1:0] mem [RING_BYTES];

	item_t              item_q;
	logic [AW-1:0]      wp_q;
	logic [AW-1:0]      rp_q;
	logic [CW-1:0]      used_q;
	logic               adm_q;
	logic [CNT32_W-1:0] bytes_q;
	logic [CNT32_W-1:0] wraps_q;
	logic [CNT32_W-1:0] pkts_q;
	logic [LEN_W-1:0]   last_q;
	logic [CNT32_W-1:0] drops_q;
	logic               rvalid_q;
	logic               dropped_q;
	logic [BYTE_W-1:0]  rd_q;
	result_t            res_q;

	logic             full;
	logic             empty;
	logic             len_zero;
	logic             fits;
	logic             store_en;
	logic [CNT32_W:0] bytes_sum;
	logic [AW-1:0]    wp_next;
	logic [AW-1:0]    rp_next;

	assign full      = (used_q == CW'(RING_BYTES));
	assign empty     = (used_q == '0);
	assign len_zero  = (item_q.packet_length == '0);
	assign fits      = !(XW'(item_q.packet_length) > XW'(MAX_PACKET)) &&
	                   !((SW'(used_q) + SW'(item_q.packet_length)) > SW'(RING_BYTES));
	assign store_en  = (item_q.command == CMD_WRITE) && !full &&
	                   (item_q.packet_start ? (!len_zero && fits) : adm_q);
	assign bytes_sum = {1'b0, bytes_q} + (CNT32_W + 1)'(item_q.packet_length);
	assign wp_next   = (wp_q == AW'(RING_BYTES - 1)) ? '0 : wp_q + 1'b1;
	assign rp_next   = (rp_q == AW'(RING_BYTES - 1)) ? '0 : rp_q + 1'b1;

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			item_q <= item;
		end
		if (dp_cmd.exec) begin
			if (store_en) begin
				mem[wp_q] <= item_q.data_byte;
			end
			rd_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			used_q    <= '0;
			adm_q     <= 1'b0;
			bytes_q   <= '0;
			wraps_q   <= '0;
			pkts_q    <= '0;
			last_q    <= '0;
			drops_q   <= '0;
			rvalid_q  <= 1'b0;
			dropped_q <= 1'b0;
		end else if (dp_cmd.exec) begin
			rvalid_q  <= 1'b0;
			dropped_q <= 1'b0;
			unique case (item_q.command)
				CMD_WRITE: begin
					dropped_q <= !store_en;
					if (store_en) begin
						wp_q   <= wp_next;
						used_q <= used_q + 1'b1;
					end
					if (item_q.packet_start) begin
						if (len_zero) begin
							adm_q <= 1'b0;
						end else begin
							bytes_q <= bytes_sum[CNT32_W-1:0];
							if (bytes_sum[CNT32_W]) begin
								wraps_q <= wraps_q + 1'b1;
							end
							pkts_q <= pkts_q + 1'b1;
							last_q <= item_q.packet_length;
							adm_q  <= fits;
							if (!fits) begin
								drops_q <= drops_q + 1'b1;
							end
						end
					end
				end
				CMD_READ: begin
					if (!empty) begin
						rvalid_q <= 1'b1;
						rp_q     <= rp_next;
						used_q   <= used_q - 1'b1;
					end
				end
				CMD_CLEAR: begin
					wp_q    <= '0;
					rp_q    <= '0;
					used_q  <= '0;
					adm_q   <= 1'b0;
					bytes_q <= '0;
					wraps_q <= '0;
					pkts_q  <= '0;
					last_q  <= '0;
					drops_q <= '0;
				end
				CMD_STATUS: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			res_q.read_byte        <= rvalid_q ? rd_q : '0;
			res_q.read_valid       <= rvalid_q;
			res_q.packet_dropped   <= dropped_q;
			res_q.bytes_available  <= AVAIL_W'(used_q);
			res_q.total_bytes      <= bytes_q;
			res_q.total_wraps      <= wraps_q;
			res_q.packet_count     <= pkts_q;
			res_q.last_packet_size <= last_q;
			res_q.dropped_packets  <= drops_q;
		end
	end

	assign result = res_q;

endmodule

/* sim/packet_admit_byte_ring_fifo_checker.sv */
`timescale 1ns / 1ps
// Checker for the packet-admitting byte ring FIFO: predicts every response and compares it.
module packet_admit_byte_ring_fifo_checker
	import pabrf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic [M_TUSER_W-1:0] m_tuser,
	output int                   fail_count,
	output int                   pending,
	output int                   req_seen,
	output int                   rsp_seen,
	output int                   pop_seen,
	output int                   drop_seen
);

	localparam int PTR_W = $clog2(RING_BYTES_DEF);
	localparam int PRINT_MAX = 40;

	logic [BYTE_W-1:0]  ring_mem [RING_BYTES_DEF];
	logic [PTR_W-1:0]   wr_ptr;
	logic [PTR_W-1:0]   rd_ptr;
	int                 fill;
	logic               admit;
	logic [CNT32_W-1:0] byte_sum;
	logic [CNT32_W-1:0] wrap_sum;
	logic [CNT32_W-1:0] pkt_sum;
	logic [CNT32_W-1:0] drop_sum;
	logic [LEN_W-1:0]   last_len;
	result_t            due_results [$];

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (fail_count < PRINT_MAX)
			$display("mismatch at %0t, response %0d: %s got %h want %h",
				$time, rsp_seen, what, got, want);
		fail_count++;
	endtask

	function automatic bit store_byte(input logic [BYTE_W-1:0] b);
		if (fill >= RING_BYTES_DEF)
			return 1'b0;
		ring_mem[wr_ptr] = b;
		wr_ptr = wr_ptr + 1'b1;
		fill++;
		return 1'b1;
	endfunction

	// applies one request to the shadow state and returns the response it should yield
	function automatic result_t admit_and_update(input item_t it);
		result_t     r;
		logic [32:0] sum;
		r = '0;
		case (it.command)
			CMD_WRITE: begin
				if (it.packet_start) begin
					if (it.packet_length == '0) begin
						admit = 1'b0;
						r.packet_dropped = 1'b1;
					end else begin
						sum = {1'b0, byte_sum} + 33'(it.packet_length);
						if (sum[32])
							wrap_sum = wrap_sum + 1;
						byte_sum = sum[31:0];
						pkt_sum = pkt_sum + 1;
						last_len = it.packet_length;
						if (int'(it.packet_length) > MAX_PACKET_DEF ||
								fill + int'(it.packet_length) > RING_BYTES_DEF) begin
							drop_sum = drop_sum + 1;
							admit = 1'b0;
							r.packet_dropped = 1'b1;
						end else begin
							admit = 1'b1;
							if (!store_byte(it.data_byte))
								r.packet_dropped = 1'b1;
						end
					end
				end else if (!admit || !store_byte(it.data_byte)) begin
					r.packet_dropped = 1'b1;
				end
			end
			CMD_READ: begin
				if (fill > 0) begin
					r.read_byte = ring_mem[rd_ptr];
					r.read_valid = 1'b1;
					rd_ptr = rd_ptr + 1'b1;
					fill--;
				end
			end
			CMD_CLEAR: begin
				wr_ptr = '0;
				rd_ptr = '0;
				fill = 0;
				admit = 1'b0;
				byte_sum = '0;
				wrap_sum = '0;
				pkt_sum = '0;
				last_len = '0;
				drop_sum = '0;
			end
			default: ;
		endcase
		r.bytes_available = AVAIL_W'(fill);
		r.total_bytes = byte_sum;
		r.total_wraps = wrap_sum;
		r.packet_count = pkt_sum;
		r.last_packet_size = last_len;
		r.dropped_packets = drop_sum;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		item_t   it;
		result_t got;
		result_t want;
		if (!arst_n) begin
			wr_ptr = '0;
			rd_ptr = '0;
			fill = 0;
			admit = 1'b0;
			byte_sum = '0;
			wrap_sum = '0;
			pkt_sum = '0;
			last_len = '0;
			drop_sum = '0;
			due_results.delete();
			fail_count = 0;
			req_seen = 0;
			rsp_seen = 0;
			pop_seen = 0;
			drop_seen = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				it.command = cmd_t'(s_tuser[1:0]);
				it.packet_start = s_tuser[2];
				it.data_byte = s_tdata[7:0];
				it.packet_length = s_tdata[17:8];
				want = admit_and_update(it);
				if (want.read_valid)
					pop_seen++;
				if (want.packet_dropped)
					drop_seen++;
				due_results.push_back(want);
				req_seen++;
			end
			if (m_tvalid && m_tready) begin
				got.read_byte = m_tdata[7:0];
				got.bytes_available = m_tdata[23:8];
				got.total_bytes = m_tdata[55:24];
				got.total_wraps = m_tdata[87:56];
				got.packet_count = m_tdata[119:88];
				got.last_packet_size = m_tdata[129:120];
				got.dropped_packets = m_tdata[161:130];
				got.read_valid = m_tuser[0];
				got.packet_dropped = m_tuser[1];
				if (due_results.size() == 0) begin
					note_mismatch("response with no request waiting", '0, '0);
				end else begin
					want = due_results.pop_front();
					if (got.read_byte !== want.read_byte)
						note_mismatch("read_byte", 32'(got.read_byte), 32'(want.read_byte));
					if (got.read_valid !== want.read_valid)
						note_mismatch("read_valid", 32'(got.read_valid),
							32'(want.read_valid));
					if (got.packet_dropped !== want.packet_dropped)
						note_mismatch("packet_dropped", 32'(got.packet_dropped),
							32'(want.packet_dropped));
					if (got.bytes_available !== want.bytes_available)
						note_mismatch("bytes_available", 32'(got.bytes_available),
							32'(want.bytes_available));
					if (got.total_bytes !== want.total_bytes)
						note_mismatch("total_bytes", got.total_bytes, want.total_bytes);
					if (got.total_wraps !== want.total_wraps)
						note_mismatch("total_wraps", got.total_wraps, want.total_wraps);
					if (got.packet_count !== want.packet_count)
						note_mismatch("packet_count", got.packet_count, want.packet_count);
					if (got.last_packet_size !== want.last_packet_size)
						note_mismatch("last_packet_size", 32'(got.last_packet_size),
							32'(want.last_packet_size));
					if (got.dropped_packets !== want.dropped_packets)
						note_mismatch("dropped_packets", got.dropped_packets,
							want.dropped_packets);
				end
				rsp_seen++;
			end
		end
		pending = due_results.size();
	end

endmodule

/* sim/tb_packet_admit_byte_ring_fifo_top.sv */
`timescale 1ns / 1ps
// Testbench top for the packet-admitting byte ring FIFO: stimulus, watchdog and verdict.
module tb_packet_admit_byte_ring_fifo_top;
	import pabrf_pkg::*;

	localparam int RANDOM_ITEMS = 525;
	localparam int IDLE_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	int fail_count;
	int pending;
	int req_seen;
	int rsp_seen;
	int pop_seen;
	int drop_seen;

	bit no_idle = 1'b0;
	int sent = 0;
	int hold_cnt = 0;
	int rdy_roll;
	int idle_cnt = 0;

	always #4 clk = ~clk;

	packet_admit_byte_ring_fifo_top u_dut (.*);

	packet_admit_byte_ring_fifo_checker u_chk (.*);

	// response side: runs of ready, short stalls, a few long ones
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (no_idle) begin
			m_tready <= 1'b1;
		end else begin
			rdy_roll = $urandom_range(0, 99);
			if (rdy_roll < 65) begin
				m_tready <= 1'b1;
				hold_cnt <= $urandom_range(0, 4);
			end else if (rdy_roll < 92) begin
				m_tready <= 1'b0;
				hold_cnt <= $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b0;
				hold_cnt <= $urandom_range(5, 30);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d responses pending",
				IDLE_LIMIT, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic send_req(input cmd_t c, input logic [BYTE_W-1:0] d, input logic st,
			input logic [LEN_W-1:0] len);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W-BYTE_W-LEN_W){1'b0}}, len, d};
		s_tuser <= {st, c};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// let the checker count the last request before waiting for pending to reach zero
	task automatic drain_wait();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// read request with junk in the unused fields
	task automatic send_pop();
		send_req(CMD_READ, 8'($urandom), 1'($urandom), 10'($urandom));
	endtask

	task automatic maybe_interleave();
		int r;
		r = $urandom_range(0, 49);
		if (r < 10)
			send_pop();
		else if (r == 10)
			send_req(CMD_STATUS, 8'($urandom), 1'($urandom), 10'($urandom));
		else if (r == 11)
			send_req(CMD_CLEAR, 8'($urandom), 1'($urandom), 10'($urandom));
	endtask

	// mostly well-formed packets; some cut short or overlong
	task automatic send_packet();
		int len;
		int body;
		int r;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
		if (len == 0)
			body = $urandom_range(0, 2);
		else if (len > 40)
			body = $urandom_range(0, 30);
		else
			body = len - 1;
		r = $urandom_range(0, 9);
		if (r == 0)
			body = body / 2;
		else if (r == 1)
			body = body + $urandom_range(1, 4);
		send_req(CMD_WRITE, 8'($urandom), 1'b1, 10'(len));
		for (int k = 0; k < body; k++) begin
			maybe_interleave();
			send_req(CMD_WRITE, 8'($urandom), 1'b0, 10'($urandom));
		end
	endtask

	initial begin
		int r;
		int stop_at;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, orphan and zero-length bytes, small and extreme packets
		send_req(CMD_STATUS, 8'h00, 1'b0, 10'd0);
		send_req(CMD_READ, 8'hFF, 1'b1, 10'h3FF);
		send_req(CMD_WRITE, 8'hC3, 1'b0, 10'd0);
		send_req(CMD_WRITE, 8'h11, 1'b1, 10'd0);
		send_req(CMD_WRITE, 8'h22, 1'b0, 10'd5);
		send_req(CMD_WRITE, 8'h00, 1'b1, 10'd1);
		send_req(CMD_READ, 8'h00, 1'b0, 10'd0);
		send_req(CMD_WRITE, 8'hFF, 1'b1, 10'd3);
		send_req(CMD_WRITE, 8'hA5, 1'b0, 10'h155);
		send_req(CMD_WRITE, 8'h5A, 1'b0, 10'h2AA);
		send_req(CMD_READ, 8'h00, 1'b0, 10'd0);
		send_req(CMD_READ, 8'h00, 1'b0, 10'd0);
		send_req(CMD_READ, 8'h00, 1'b0, 10'd0);
		send_req(CMD_READ, 8'h00, 1'b0, 10'd0);
		send_req(CMD_WRITE, 8'h80, 1'b1, 10'h3FF);
		send_req(CMD_WRITE, 8'h01, 1'b0, 10'd0);
		send_req(CMD_STATUS, 8'hFF, 1'b1, 10'h3FF);
		send_req(CMD_CLEAR, 8'h00, 1'b0, 10'd0);
		send_req(CMD_READ, 8'h00, 1'b0, 10'd0);
		send_req(CMD_WRITE, 8'h7F, 1'b1, 10'h200);
		send_req(CMD_WRITE, 8'hFE, 1'b0, 10'd0);
		send_req(CMD_READ, 8'h00, 1'b0, 10'd0);
		send_req(CMD_READ, 8'h00, 1'b0, 10'd0);
		drain_wait();

		// random traffic
		stop_at = sent + RANDOM_ITEMS;
		while (sent < stop_at) begin
			no_idle = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_packet();
			end else if (r < 80) begin
				repeat ($urandom_range(1, 12)) send_pop();
			end else if (r < 88) begin
				send_req(CMD_STATUS, 8'($urandom), 1'($urandom), 10'($urandom));
			end else if (r < 92) begin
				send_req(CMD_CLEAR, 8'($urandom), 1'($urandom), 10'($urandom));
			end else if (r < 97) begin
				send_req(CMD_WRITE, 8'($urandom), 1'b0, 10'($urandom));
			end else begin
				send_req(CMD_WRITE, 8'($urandom), 1'b1, 10'd0);
			end
			if (r == 50)
				drain_wait();
		end
		no_idle = 1'b0;

		drain_wait();
		repeat (20) @(posedge clk);
		$display("run: %0d requests, %0d responses, %0d bytes popped, %0d drop flags",
			req_seen, rsp_seen, pop_seen, drop_seen);
		$display("run: directed edge cases, then random packets, pops, clears and stalls");
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
